// ===== hdl/quicksort_key_tag_sorter_unit_defines.svh =====
// Assertion macros shared by the sorter RTL.
// No dependencies.
`ifndef QUICKSORT_KEY_TAG_SORTER_UNIT_DEFINES_SVH
`define QUICKSORT_KEY_TAG_SORTER_UNIT_DEFINES_SVH
// check that a condition implies a consequence on the next edge
`define QS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qs check failed");
// check that a condition implies another in the same cycle
`define QS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qs check failed");
`endif

// ===== hdl/qsort_pkg.sv =====
// Package for the quicksort record sorter: sizes, codes, record type.
// No dependencies.
package qsort_pkg;
	localparam int MaxRecords = 64;
	localparam int IdxW = $clog2(MaxRecords);
	localparam int CntW = IdxW + 1;
	localparam logic [15:0] LfsrTaps = 16'hB400;
	localparam logic [1:0] SchemeLomuto = 2'd0;
	localparam logic [1:0] SchemeRandom = 2'd1;
	localparam logic [1:0] SchemeHoare = 2'd2;
	localparam logic RegScheme = 1'b0;
	localparam logic RegSeed = 1'b1;

	typedef struct packed {
		logic signed [31:0] key;
		logic [7:0] tag;
	} rec_t;

	typedef struct packed {
		logic start;
		logic [IdxW-1:0] a;
	} mod_cmd_t;

	typedef struct packed {
		logic busy;
		logic [IdxW-1:0] q;
	} mod_sts_t;
endpackage

// ===== hdl/qsort_if.sv =====
// Valid/ready channel interface for records in and out.
// Depends on nothing.
interface qsort_if;
	logic valid;
	logic ready;
	logic signed [31:0] key;
	logic [7:0] tag;
	logic last;
	modport source (output valid, key, tag, last, input ready);
	modport sink (input valid, key, tag, last, output ready);
endinterface

// ===== hdl/qsort_mod.sv =====
// Iterative modulo unit: remainder of a 16-bit value by a 6-bit divisor, plus an offset.
// Depends on qsort_pkg.
module qsort_mod (
	input logic clk,
	input logic arst_n,
	input logic [15:0] dividend,
	input logic [qsort_pkg::IdxW-1:0] divisor,
	input qsort_pkg::mod_cmd_t cmd,
	output qsort_pkg::mod_sts_t sts
);
	logic [15:0] num_q;
	logic [qsort_pkg::IdxW:0] rem_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [qsort_pkg::IdxW+1:0] trial;

	assign trial = {rem_q, num_q[15]} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy_q <= 1'b0;
		end
	end

	// restoring division, one bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[14:0], 1'b0};
			if (!trial[qsort_pkg::IdxW+1])
				rem_q <= trial[qsort_pkg::IdxW:0];
			else
				rem_q <= {rem_q[qsort_pkg::IdxW-1:0], num_q[15]};
		end
	end

	assign sts.busy = busy_q;
	assign sts.q = rem_q[qsort_pkg::IdxW-1:0] + cmd.a;

	`include "quicksort_key_tag_sorter_unit_defines.svh"
	`QS_ASSERT_NEXT(a_mod_start, cmd.start, busy_q)
	`QS_ASSERT_NOW(a_mod_cnt, busy_q, cnt_q != 5'd0)
	`QS_ASSERT_NOW(a_mod_rem, busy_q, rem_q < {1'b0, divisor})
endmodule

// ===== hdl/quicksort_key_tag_sorter_unit.sv =====
// Quicksort key/tag sorter top level: record store, range stack, sequencer.
// Per range: pop and select, then a scan of the range with a registered store read per record,
// and a swap through the store for each record moved; a random pivot first runs the modulo
// unit and a swap. Output: each record is held on out_ch until out_ch.ready takes it.
// Throughput: one batch at a time; in_ch.ready is low from batch end until the last result.
// Reset: asynchronous active low; clears count, stack pointer, state, scheme and LFSR (to 1).
module quicksort_key_tag_sorter_unit (
	input logic clk,
	input logic arst_n,
	qsort_if.sink in_ch,
	qsort_if.source out_ch,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data
);
	localparam int W = qsort_pkg::IdxW;
	localparam logic [W:0] Full = (W+1)'(qsort_pkg::MaxRecords);
	localparam logic [4:0] StLoad = 5'd0, StPop = 5'd1, StPopW = 5'd2, StSel = 5'd3,
		StRndGo = 5'd4, StRndW = 5'd5, StLPiv = 5'd6, StLPivW = 5'd7, StLRd = 5'd8,
		StLCmp = 5'd9, StLEnd = 5'd10, StHPiv = 5'd11, StHPivW = 5'd12, StHJRd = 5'd13,
		StHJCmp = 5'd14, StHIRd = 5'd15, StHICmp = 5'd16, StSwA = 5'd17, StSwB = 5'd18,
		StSwC = 5'd19, StSwD = 5'd20, StPushR = 5'd21, StPushL = 5'd22, StOut = 5'd23,
		StOutW = 5'd24, StOutHold = 5'd25;

	qsort_pkg::rec_t mem [qsort_pkg::MaxRecords];
	logic [2*W-1:0] stk [qsort_pkg::MaxRecords];

	logic [4:0] st_q, ret_q;
	logic [1:0] scheme_q;
	logic [15:0] lfsr_q;
	logic [W:0] cnt_q, sp_q;
	logic [W-1:0] lo_q, hi_q, i_q, j_q, q_q, pa_q, pb_q, out_i_q;
	qsort_pkg::rec_t rd_q, pivot_q, tmp_q, out_r_q;
	logic [2*W-1:0] srd_q;
	logic out_v_q;
	logic out_last_q;
	logic [W-1:0] ra;
	logic we;
	logic [W-1:0] wa;
	qsort_pkg::rec_t wd;
	logic swe;
	logic [2*W-1:0] swd;
	qsort_pkg::mod_cmd_t mcmd;
	qsort_pkg::mod_sts_t msts;
	logic [15:0] lfsr_nx;
	logic lfsr_step;
	logic le_rp, le_pr;
	logic in_fire;
	logic [W:0] n_new;
	logic right_ok, left_ok;
	logic [W-1:0] left_hi;

	assign lfsr_nx = lfsr_q[0] ? ({1'b0, lfsr_q[15:1]} ^ qsort_pkg::LfsrTaps)
		: {1'b0, lfsr_q[15:1]};
	assign lfsr_step = (st_q == StSel) && (lo_q < hi_q) && (scheme_q == qsort_pkg::SchemeRandom);
	assign le_rp = $signed(rd_q.key) <= $signed(pivot_q.key);
	assign le_pr = $signed(pivot_q.key) <= $signed(rd_q.key);
	assign in_fire = in_ch.valid && in_ch.ready;
	// a record arriving at a full store is dropped
	assign n_new = (cnt_q == Full) ? cnt_q : cnt_q + (W+1)'(1);
	assign right_ok = ({1'b0, q_q} + (W+1)'(1)) < {1'b0, hi_q};
	assign left_ok = (scheme_q == qsort_pkg::SchemeHoare) ? (lo_q < q_q)
		: (({1'b0, lo_q} + (W+1)'(1)) < {1'b0, q_q});
	assign left_hi = (scheme_q == qsort_pkg::SchemeHoare) ? q_q : q_q - W'(1);

	qsort_mod u_mod (.clk(clk), .arst_n(arst_n), .dividend(lfsr_q),
		.divisor(hi_q - lo_q), .cmd(mcmd), .sts(msts));

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (swe) stk[sp_q[W-1:0]] <= swd;
		srd_q <= stk[sp_q[W-1:0] - W'(1)];
	end

	always_comb begin
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = '0;
		swe = 1'b0;
		swd = '0;
		mcmd = '0;
		mcmd.a = lo_q;
		case (st_q)
			StLoad: if (in_fire && cnt_q != Full) begin
				we = 1'b1;
				wa = cnt_q[W-1:0];
				wd = '{key: in_ch.key, tag: in_ch.tag};
			end
			StRndGo: mcmd.start = 1'b1;
			StLPiv: ra = hi_q;
			StLRd: ra = j_q;
			StHPiv: ra = lo_q;
			StHJRd: ra = j_q;
			StHIRd: ra = i_q;
			StSwA: ra = pa_q;
			StSwB: ra = pb_q;
			StSwC: begin
				we = 1'b1;
				wa = pa_q;
				wd = rd_q;
			end
			StSwD: begin
				we = 1'b1;
				wa = pb_q;
				wd = tmp_q;
			end
			StPushR: begin
				swe = right_ok;
				swd = {q_q + W'(1), hi_q};
			end
			StPushL: begin
				swe = left_ok;
				swd = {lo_q, left_hi};
			end
			StOut: ra = out_i_q;
			default: ;
		endcase
	end

	assign in_ch.ready = (st_q == StLoad);
	assign out_ch.valid = out_v_q;
	assign out_ch.key = out_r_q.key;
	assign out_ch.tag = out_r_q.tag;
	assign out_ch.last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q <= qsort_pkg::SchemeLomuto;
			lfsr_q <= 16'd1;
		end else begin
			if (cfg_we && cfg_index == qsort_pkg::RegScheme) scheme_q <= cfg_data[1:0];
			if (cfg_we && cfg_index == qsort_pkg::RegSeed)
				lfsr_q <= (cfg_data == '0) ? 16'd1 : cfg_data;
			else if (lfsr_step)
				lfsr_q <= lfsr_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StLoad;
			ret_q <= StLoad;
			cnt_q <= '0;
			sp_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			i_q <= '0;
			j_q <= '0;
			q_q <= '0;
			pa_q <= '0;
			pb_q <= '0;
			out_i_q <= '0;
			pivot_q <= '0;
			tmp_q <= '0;
			out_v_q <= 1'b0;
			out_r_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			case (st_q)
				StLoad: if (in_fire) begin
					cnt_q <= n_new;
					if (in_ch.last) begin
						sp_q <= '0;
						lo_q <= '0;
						hi_q <= n_new[W-1:0] - W'(1);
						out_i_q <= '0;
						st_q <= (n_new < (W+1)'(2)) ? StOut : StSel;
					end
				end
				StPop: if (sp_q == '0) begin
					out_i_q <= '0;
					st_q <= StOut;
				end else begin
					sp_q <= sp_q - (W+1)'(1);
					st_q <= StPopW;
				end
				StPopW: begin
					lo_q <= srd_q[2*W-1:W];
					hi_q <= srd_q[W-1:0];
					st_q <= StSel;
				end
				StSel: begin
					if (lo_q >= hi_q) st_q <= StPop;
					else if (scheme_q == qsort_pkg::SchemeHoare) st_q <= StHPiv;
					else if (scheme_q == qsort_pkg::SchemeRandom) st_q <= StRndGo;
					else st_q <= StLPiv;
				end
				StRndGo: st_q <= StRndW;
				// move the random pivot to the top of the range
				StRndW: if (!msts.busy) begin
					pa_q <= msts.q;
					pb_q <= hi_q;
					ret_q <= StLPiv;
					st_q <= StSwA;
				end
				StLPiv: st_q <= StLPivW;
				StLPivW: begin
					pivot_q <= rd_q;
					i_q <= lo_q;
					j_q <= lo_q;
					st_q <= StLRd;
				end
				StLRd: st_q <= (j_q == hi_q) ? StLEnd : StLCmp;
				StLCmp: if (le_rp) begin
					pa_q <= i_q;
					pb_q <= j_q;
					i_q <= i_q + W'(1);
					j_q <= j_q + W'(1);
					ret_q <= StLRd;
					st_q <= StSwA;
				end else begin
					j_q <= j_q + W'(1);
					st_q <= StLRd;
				end
				StLEnd: begin
					pa_q <= i_q;
					pb_q <= hi_q;
					q_q <= i_q;
					ret_q <= StPushR;
					st_q <= StSwA;
				end
				StHPiv: st_q <= StHPivW;
				StHPivW: begin
					pivot_q <= rd_q;
					i_q <= lo_q;
					j_q <= hi_q;
					st_q <= StHJRd;
				end
				StHJRd: st_q <= StHJCmp;
				StHJCmp: if (j_q > lo_q && !le_rp) begin
					j_q <= j_q - W'(1);
					st_q <= StHJRd;
				end else begin
					st_q <= StHIRd;
				end
				StHIRd: st_q <= StHICmp;
				StHICmp: if (i_q < hi_q && !le_pr) begin
					i_q <= i_q + W'(1);
					st_q <= StHIRd;
				end else if (i_q < j_q) begin
					pa_q <= i_q;
					pb_q <= j_q;
					i_q <= i_q + W'(1);
					j_q <= j_q - W'(1);
					ret_q <= StHJRd;
					st_q <= StSwA;
				end else begin
					q_q <= j_q;
					st_q <= StPushR;
				end
				StSwA: st_q <= StSwB;
				StSwB: begin
					tmp_q <= rd_q;
					st_q <= StSwC;
				end
				StSwC: st_q <= StSwD;
				StSwD: st_q <= ret_q;
				// push right part first so the left part is popped first
				StPushR: begin
					if (swe) sp_q <= sp_q + (W+1)'(1);
					st_q <= StPushL;
				end
				StPushL: begin
					if (swe) sp_q <= sp_q + (W+1)'(1);
					st_q <= StPop;
				end
				StOut: st_q <= StOutW;
				StOutW: begin
					out_v_q <= 1'b1;
					out_r_q <= rd_q;
					out_last_q <= (({1'b0, out_i_q} + (W+1)'(1)) == cnt_q);
					st_q <= StOutHold;
				end
				// hold the transaction until it is taken
				StOutHold: if (out_ch.ready) begin
					out_v_q <= 1'b0;
					if (out_last_q) begin
						cnt_q <= '0;
						st_q <= StLoad;
					end else begin
						out_i_q <= out_i_q + W'(1);
						st_q <= StOut;
					end
				end
				default: st_q <= StLoad;
			endcase
		end
	end

	`include "quicksort_key_tag_sorter_unit_defines.svh"
	`QS_ASSERT_NOW(a_sp_bound, 1'b1, sp_q <= Full)
	`QS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= Full)
	`QS_ASSERT_NOW(a_lfsr_nz, 1'b1, lfsr_q != 16'd0)
	`QS_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.key))
	`QS_ASSERT_NOW(a_in_idle, out_ch.valid, !in_ch.ready)
endmodule

// ===== tb/quicksort_key_tag_sorter_unit_test.sv =====
// Self-checking testbench for the quicksort key/tag sorter: directed records and random batches under
// every partition scheme, checked against a built-in sort predictor.
// Depends on qsort_pkg, qsort_if and quicksort_key_tag_sorter_unit.
`timescale 1ns / 1ps
module quicksort_key_tag_sorter_unit_test;
	typedef struct {
		logic signed [31:0] key;
		logic [7:0] tag;
		logic last;
	} record_t;

	localparam int StallLimit = 200000;
	localparam int DrainCycles = 40;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;

	qsort_if in_ch();
	qsort_if out_ch();

	quicksort_key_tag_sorter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic signed [31:0] held_keys [qsort_pkg::MaxRecords];
	logic [7:0] held_tags [qsort_pkg::MaxRecords];
	int held_count;
	logic [1:0] cur_scheme;
	logic [15:0] pivot_lfsr;

	record_t pending_records [$];
	record_t sorted_expect [$];
	int fail_count;
	int stall_cycles;
	bit quiet;
	int send_gap;
	int recv_gap;

	always #5 clk = ~clk;

	function automatic void swap_held(int a, int b);
		logic signed [31:0] k;
		logic [7:0] t;
		k = held_keys[a]; held_keys[a] = held_keys[b]; held_keys[b] = k;
		t = held_tags[a]; held_tags[a] = held_tags[b]; held_tags[b] = t;
	endfunction

	function automatic int lomuto_split(int lo, int hi);
		logic signed [31:0] pivot;
		int i;
		pivot = held_keys[hi];
		i = lo;
		for (int j = lo; j < hi; j++) begin
			if (held_keys[j] <= pivot) begin
				swap_held(i, j);
				i++;
			end
		end
		swap_held(i, hi);
		return i;
	endfunction

	function automatic int hoare_split(int lo, int hi);
		logic signed [31:0] pivot;
		int i;
		int j;
		pivot = held_keys[lo];
		i = lo - 1;
		j = hi + 1;
		forever begin
			do j--; while (j > lo && !(held_keys[j] <= pivot));
			do i++; while (i < hi && !(pivot <= held_keys[i]));
			if (i < j) swap_held(i, j);
			else return j;
		end
	endfunction

	function automatic int random_split(int lo, int hi);
		logic shifted;
		int idx;
		shifted = pivot_lfsr[0];
		pivot_lfsr = pivot_lfsr >> 1;
		if (shifted) pivot_lfsr = pivot_lfsr ^ qsort_pkg::LfsrTaps;
		idx = lo + int'(32'(pivot_lfsr) % 32'(hi - lo));
		swap_held(idx, hi);
		return lomuto_split(lo, hi);
	endfunction

	// depth-first quicksort, left range finished before right
	function automatic void sort_held();
		int lo_stack [$];
		int hi_stack [$];
		int lo;
		int hi;
		int q;
		int lhi;
		if (held_count < 2) return;
		lo_stack.push_back(0);
		hi_stack.push_back(held_count - 1);
		while (lo_stack.size() > 0) begin
			lo = lo_stack.pop_back();
			hi = hi_stack.pop_back();
			if (lo >= hi) continue;
			if (cur_scheme == qsort_pkg::SchemeHoare) begin
				q = hoare_split(lo, hi);
				lhi = q;
			end else begin
				q = (cur_scheme == qsort_pkg::SchemeRandom) ? random_split(lo, hi)
					: lomuto_split(lo, hi);
				lhi = q - 1;
			end
			if (q + 1 < hi && lo_stack.size() < qsort_pkg::MaxRecords) begin
				lo_stack.push_back(q + 1);
				hi_stack.push_back(hi);
			end
			if (lo < lhi && lo_stack.size() < qsort_pkg::MaxRecords) begin
				lo_stack.push_back(lo);
				hi_stack.push_back(lhi);
			end
		end
	endfunction

	function automatic void take_record(record_t r);
		record_t e;
		if (held_count < qsort_pkg::MaxRecords) begin
			held_keys[held_count] = r.key;
			held_tags[held_count] = r.tag;
			held_count++;
		end
		if (!r.last) return;
		sort_held();
		for (int k = 0; k < held_count; k++) begin
			e.key = held_keys[k];
			e.tag = held_tags[k];
			e.last = (k == held_count - 1);
			sorted_expect.push_back(e);
		end
		held_count = 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (pending_records.size() > 0) begin
				record_t r;
				r = pending_records.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.key <= r.key;
				in_ch.tag <= r.tag;
				in_ch.last <= r.last;
				if (!quiet && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 3);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result sink stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			recv_gap <= $urandom_range(0, 2);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				record_t r;
				r.key = in_ch.key;
				r.tag = in_ch.tag;
				r.last = in_ch.last;
				take_record(r);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (sorted_expect.size() == 0) begin
					$display("%0t: unexpected record key=%0d tag=%0d last=%0b", $time,
						out_ch.key, out_ch.tag, out_ch.last);
					fail_count++;
				end else begin
					record_t e;
					e = sorted_expect.pop_front();
					if (out_ch.key !== e.key || out_ch.tag !== e.tag || out_ch.last !== e.last) begin
						$display("%0t: mismatch expected key=%0d tag=%0d last=%0b, actual key=%0d tag=%0d last=%0b",
							$time, e.key, e.tag, e.last, out_ch.key, out_ch.tag, out_ch.last);
						fail_count++;
					end
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallLimit) begin
				$display("quicksort_key_tag_sorter_unit_test: FAIL");
				$finish;
			end
		end
	end

	task automatic add_record(logic signed [31:0] key, logic [7:0] tag, logic last);
		record_t r;
		r.key = key;
		r.tag = tag;
		r.last = last;
		pending_records.push_back(r);
	endtask

	// shape: 0 full range, 1 heavy duplicates, 2 ascending, 3 descending
	task automatic add_batch(int n, int shape);
		logic signed [31:0] k;
		for (int i = 0; i < n; i++) begin
			case (shape)
				1: k = $signed($urandom_range(0, 6)) - 3;
				2: k = -1000 + i * 7;
				3: k = 1000 - i * 7;
				default: k = $urandom;
			endcase
			add_record(k, 8'($urandom_range(0, 255)), i == n - 1);
		end
	endtask

	task automatic drain();
		wait (pending_records.size() == 0 && !in_ch.valid && sorted_expect.size() == 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == qsort_pkg::RegScheme) begin
			cur_scheme = value[1:0];
		end else begin
			pivot_lfsr = (value == 16'd0) ? 16'd1 : value;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int items, int big_batch);
		int sent;
		int n;
		sent = 0;
		if (big_batch > 0) begin
			add_batch(big_batch, $urandom_range(0, 3));
			sent = big_batch;
		end
		while (sent < items) begin
			n = $urandom_range(1, 12);
			add_batch(n, $urandom_range(0, 3));
			sent += n;
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = qsort_pkg::RegScheme;
		cfg_data = 16'd0;
		in_ch.valid = 1'b0;
		in_ch.key = '0;
		in_ch.tag = '0;
		in_ch.last = 1'b0;
		out_ch.ready = 1'b0;
		held_count = 0;
		cur_scheme = qsort_pkg::SchemeLomuto;
		pivot_lfsr = 16'd1;
		fail_count = 0;
		stall_cycles = 0;
		quiet = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: single record, extremes, duplicates
		add_record(32'sh8000_0000, 8'hFF, 1'b1);
		add_record(32'sh7FFF_FFFF, 8'h00, 1'b0);
		add_record(32'sh8000_0000, 8'hFF, 1'b1);
		add_record(0, 8'h01, 1'b0);
		add_record(0, 8'h02, 1'b0);
		add_record(0, 8'h03, 1'b1);
		add_record(32'sh7FFF_FFFF, 8'hAA, 1'b0);
		add_record(-1, 8'h55, 1'b0);
		add_record(32'sh8000_0000, 8'h00, 1'b0);
		add_record(1, 8'hFF, 1'b0);
		add_record(0, 8'h80, 1'b1);
		drain();

		// hold off until all results are out, then switch schemes
		write_reg(qsort_pkg::RegScheme, 16'(qsort_pkg::SchemeRandom));
		write_reg(qsort_pkg::RegSeed, 16'd0);
		random_phase(66, 0);
		write_reg(qsort_pkg::RegScheme, 16'(qsort_pkg::SchemeHoare));
		random_phase(70, 66);
		write_reg(qsort_pkg::RegScheme, 16'd3);
		write_reg(qsort_pkg::RegSeed, 16'hFFFF);
		random_phase(66, 0);
		write_reg(qsort_pkg::RegScheme, 16'(qsort_pkg::SchemeRandom));
		random_phase(70, 64);
		write_reg(qsort_pkg::RegScheme, 16'(qsort_pkg::SchemeLomuto));
		random_phase(66, 0);
		write_reg(qsort_pkg::RegScheme, 16'(qsort_pkg::SchemeHoare));
		write_reg(qsort_pkg::RegSeed, 16'h5A3C);
		quiet = 1'b1;
		random_phase(60, 0);

		if (fail_count == 0) $display("quicksort_key_tag_sorter_unit_test: PASS");
		else $display("quicksort_key_tag_sorter_unit_test: FAIL");
		$finish;
	end
endmodule
